// ===== design/tgr_pkg.sv =====
// shared types, codes and helpers of the touch gesture recognizer
// no dependencies
`default_nettype none

package tgr_pkg;

    localparam int COORD_BITS   = 12;
    localparam int STABLE_COUNT = 3;
    localparam int SUM_BITS     = 14;
    localparam int ACC_BITS     = 16;
    localparam logic [31:0] TAP_MIN_MS = 32'd50;
    // reciprocal of three in 0.16 fixed point, exact for numerators below 2^15
    localparam logic [14:0] RECIP3 = 15'd21846;

    // gesture codes
    localparam logic [3:0] EV_PLAY_PAUSE  = 4'd0;
    localparam logic [3:0] EV_BACK_PLAYER = 4'd1;
    localparam logic [3:0] EV_SELECT_ITEM = 4'd2;
    localparam logic [3:0] EV_LIST_TMO    = 4'd3;
    localparam logic [3:0] EV_BRIGHT_UP   = 4'd4;
    localparam logic [3:0] EV_BRIGHT_DN   = 4'd5;
    localparam logic [3:0] EV_PREV        = 4'd6;
    localparam logic [3:0] EV_NEXT        = 4'd7;
    localparam logic [3:0] EV_VOL_UP      = 4'd8;
    localparam logic [3:0] EV_VOL_DN      = 4'd9;
    localparam logic [3:0] EV_LONG_LEFT   = 4'd10;
    localparam logic [3:0] EV_LONG_RIGHT  = 4'd11;
    localparam logic [3:0] EV_LIST_UP     = 4'd12;
    localparam logic [3:0] EV_LIST_DN     = 4'd13;

    // screen modes
    localparam logic [1:0] MODE_PLAYER = 2'd0;
    localparam logic [1:0] MODE_LIST   = 2'd1;
    localparam logic [1:0] MODE_VOLUME = 2'd2;
    localparam logic [1:0] MODE_OTHER  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_WIDTH    = 3'd1;
    localparam logic [2:0] REG_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_SLIDE    = 3'd3;
    localparam logic [2:0] REG_TAP_MAX  = 3'd4;
    localparam logic [2:0] REG_LONG     = 3'd5;
    localparam logic [2:0] REG_LIST_TMO = 3'd6;
    localparam logic [2:0] REG_VOL_TMO  = 3'd7;

    typedef struct packed {
        logic                  touched;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [31:0]           now_ms;
        logic [1:0]            mode;
    } t_item;

    typedef struct packed {
        logic [3:0] code;
        logic       last;
    } t_event;

    typedef struct packed {
        logic        enabled;
        logic [11:0] width;
        logic [11:0] height;
        logic [9:0]  slide_th;
        logic [15:0] tap_max;
        logic [15:0] long_press;
        logic [15:0] list_tmo;
        logic [15:0] vol_tmo;
    } t_cfg;

    // quotient of a sum by a sample count of 0..3
    function automatic logic [SUM_BITS-1:0] div_small(input logic [SUM_BITS-1:0] num,
                                                      input logic [1:0] den);
        logic [SUM_BITS+14:0] prod;
        begin
            prod = SUM_BITS'(num) * RECIP3;
            case (den)
                2'd1:    div_small = num;
                2'd2:    div_small = num >> 1;
                2'd3:    div_small = SUM_BITS'(prod[SUM_BITS+14:16]);
                default: div_small = '0;
            endcase
        end
    endfunction

    // magnitude of a 16-bit two's complement value
    function automatic logic [ACC_BITS:0] abs16(input logic [ACC_BITS-1:0] v);
        begin
            abs16 = v[ACC_BITS-1] ? ((ACC_BITS+1)'(~v) + 1'b1) : {1'b0, v};
            if (v[ACC_BITS-1]) abs16 = (ACC_BITS+1)'({1'b0, ~v}) + 1'b1;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/tgr_front.sv =====
// input side: clamps coordinates and holds reports in a two-entry queue
// depends on tgr_pkg
`default_nettype none

module tgr_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    output logic                              o_full,
    input  wire logic                         i_touched,
    input  wire logic [tgr_pkg::COORD_BITS-1:0] i_pos_x,
    input  wire logic [tgr_pkg::COORD_BITS-1:0] i_pos_y,
    input  wire logic [31:0]                  i_now_ms,
    input  wire logic [1:0]                   i_screen_mode,
    input  wire logic [11:0]                  i_width,
    input  wire logic [11:0]                  i_height,
    output logic                              o_valid,
    output tgr_pkg::t_item                    o_item,
    input  wire logic                         i_pop
);
    import tgr_pkg::*;

    t_item       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_item       w_in;
    logic        w_wr, w_rd;

    function automatic logic [COORD_BITS-1:0] clamp(input logic [COORD_BITS-1:0] c,
                                                    input logic [11:0] size);
        begin
            if (size == 12'd0) clamp = '0;
            else if (12'(c) >= size) clamp = COORD_BITS'(size - 12'd1);
            else clamp = c;
        end
    endfunction

    always_comb begin
        w_in.touched = i_touched;
        // untouched reports carry coordinate zero
        w_in.x       = i_touched ? clamp(i_pos_x, i_width)  : '0;
        w_in.y       = i_touched ? clamp(i_pos_y, i_height) : '0;
        w_in.now_ms  = i_now_ms;
        w_in.mode    = i_screen_mode;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

`default_nettype wire

// ===== design/tgr_evq.sv =====
// result side: four-entry event queue, takes up to two events per cycle
// depends on tgr_pkg
`default_nettype none

module tgr_evq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [1:0]      i_wr_n,
    input  tgr_pkg::t_event      i_ev0,
    input  tgr_pkg::t_event      i_ev1,
    output logic [2:0]           o_count,
    output logic                 o_empty,
    output tgr_pkg::t_event      o_head,
    input  wire logic            i_pop
);
    import tgr_pkg::*;

    t_event      r_mem [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;
    logic        w_rd;

    assign o_count = r_cnt;
    assign o_empty = (r_cnt == 3'd0);
    assign o_head  = r_mem[r_rp];
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr_n != 2'd0) r_mem[r_wp] <= i_ev0;
        if (i_wr_n == 2'd2) r_mem[r_wp + 2'd1] <= i_ev1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + i_wr_n;
            if (w_rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_wr_n) - 3'(w_rd);
        end
    end

endmodule

`default_nettype wire

// ===== design/tgr_core.sv =====
// back end: press tracking state, averaging divider and gesture decisions
// depends on tgr_pkg
`default_nettype none

module tgr_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  tgr_pkg::t_cfg        i_cfg,
    input  wire logic            i_valid,
    input  tgr_pkg::t_item       i_item,
    output logic                 o_pop,
    input  wire logic [2:0]      i_q_count,
    output logic [1:0]           o_wr_n,
    output tgr_pkg::t_event      o_ev0,
    output tgr_pkg::t_event      o_ev1
);
    import tgr_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PRESS = 2'd1;
    localparam logic [1:0] PH_DRAG = 2'd2;
    localparam logic [1:0] PH_LONG = 2'd3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_Q0   = 3'd1;
    localparam logic [2:0] S_Q1   = 3'd2;
    localparam logic [2:0] S_Q2   = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;

    logic [2:0]            r_state;
    t_item                 r_item;
    logic [SUM_BITS-1:0]   r_ty, r_rx, r_ry;

    logic [1:0]            r_phase, n_phase;
    logic [31:0]           r_press_ms, n_press_ms;
    logic [31:0]           r_last_ms, n_last_ms;
    logic [COORD_BITS-1:0] r_ref_x, n_ref_x, r_ref_y, n_ref_y;
    logic [SUM_BITS-1:0]   r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic [1:0]            r_count, n_count;
    logic [ACC_BITS-1:0]   r_acc_dx, n_acc_dx, r_acc_dy, n_acc_dy;
    logic                  r_slid, n_slid;

    logic [SUM_BITS-1:0]   w_num;
    logic [1:0]            w_den;
    logic [SUM_BITS-1:0]   w_quot;
    logic                  w_grow;
    logic [11:0]           w_upper, w_right, w_half;
    logic [13:0]           w_h3;
    logic [27:0]           w_w2p;
    logic                  w_fire;
    logic [3:0]            w_code [2];
    logic [1:0]            w_n;

    // stabilizing adds a sample only while fewer than the full count are held
    assign w_grow = (r_count < 2'(STABLE_COUNT));

    always_comb begin
        unique case (r_state)
            S_Q0: begin
                w_num = r_sum_y;
                w_den = r_count;
            end
            S_Q1: begin
                w_num = w_grow ? r_sum_x + SUM_BITS'(r_item.x) : r_sum_x;
                w_den = w_grow ? r_count + 2'd1 : r_count;
            end
            S_Q2: begin
                w_num = w_grow ? r_sum_y + SUM_BITS'(r_item.y) : r_sum_y;
                w_den = w_grow ? r_count + 2'd1 : r_count;
            end
            default: begin
                w_num = r_sum_y;
                w_den = r_count;
            end
        endcase
        w_quot = div_small(w_num, w_den);
    end

    // region bounds: three quarters of the height, two thirds and half of the width
    always_comb begin
        w_h3    = 14'(i_cfg.height) * 14'd3;
        w_upper = w_h3[13:2];
        w_w2p   = 28'({i_cfg.width, 1'b0}) * 28'(RECIP3);
        w_right = w_w2p[27:16];
        w_half  = {1'b0, i_cfg.width[11:1]};
    end

    assign w_fire = (r_state == S_EXEC) && (i_q_count <= 3'd2);
    assign o_pop  = (r_state == S_IDLE) && i_valid;

    always_comb begin
        logic [31:0]         dt;
        logic [SUM_BITS-1:0] ty;
        logic [ACC_BITS-1:0] adx, ady;
        logic [ACC_BITS:0]   mx, my;
        logic [9:0]          th;
        n_phase    = r_phase;
        n_press_ms = r_press_ms;
        n_last_ms  = r_last_ms;
        n_ref_x    = r_ref_x;
        n_ref_y    = r_ref_y;
        n_sum_x    = r_sum_x;
        n_sum_y    = r_sum_y;
        n_count    = r_count;
        n_acc_dx   = r_acc_dx;
        n_acc_dy   = r_acc_dy;
        n_slid     = r_slid;
        w_code[0]  = EV_PLAY_PAUSE;
        w_code[1]  = EV_PLAY_PAUSE;
        w_n        = 2'd0;
        th         = i_cfg.slide_th;
        dt         = '0;
        ty         = '0;
        adx        = '0;
        ady        = '0;
        mx         = '0;
        my         = '0;

        if (!i_cfg.enabled || (!r_item.touched && r_phase == PH_IDLE)) begin
            w_n = 2'd0;
        end else if (r_phase == PH_LONG) begin
            if (!r_item.touched) begin
                n_phase = PH_IDLE;
                n_slid  = 1'b0;
            end
        end else begin
            if (r_item.touched) begin
                n_last_ms = r_item.now_ms;
            end else begin
                dt = r_item.now_ms - r_last_ms;
                if (r_item.mode == MODE_LIST && dt > 32'(i_cfg.list_tmo)) begin
                    w_code[w_n[0]] = EV_LIST_TMO;
                    w_n = w_n + 2'd1;
                    n_last_ms = r_item.now_ms;
                end
                if (r_item.mode == MODE_VOLUME && dt > 32'(i_cfg.vol_tmo)) begin
                    w_code[w_n[0]] = EV_BACK_PLAYER;
                    w_n = w_n + 2'd1;
                    n_last_ms = r_item.now_ms;
                end
                dt = r_item.now_ms - r_press_ms;
                if (!r_slid && dt > TAP_MIN_MS && dt < 32'(i_cfg.tap_max)) begin
                    ty = (r_count != 2'd0) ? r_ty : SUM_BITS'(r_item.y);
                    if (r_item.mode == MODE_PLAYER && ty < SUM_BITS'(w_upper)) begin
                        w_code[w_n[0]] = EV_PLAY_PAUSE;
                        w_n = w_n + 2'd1;
                    end else if (r_item.mode == MODE_VOLUME) begin
                        w_code[w_n[0]] = EV_BACK_PLAYER;
                        w_n = w_n + 2'd1;
                    end else if (r_item.mode == MODE_LIST) begin
                        w_code[w_n[0]] = EV_SELECT_ITEM;
                        w_n = w_n + 2'd1;
                    end
                end
                n_phase = PH_IDLE;
                n_slid  = 1'b0;
            end

            if (r_item.touched && r_item.mode != MODE_OTHER) begin
                if (r_phase == PH_IDLE) begin
                    n_phase    = PH_PRESS;
                    n_press_ms = r_item.now_ms;
                    n_sum_x    = SUM_BITS'(r_item.x);
                    n_sum_y    = SUM_BITS'(r_item.y);
                    n_count    = 2'd1;
                    n_slid     = 1'b0;
                end else if (r_phase == PH_PRESS) begin
                    if (w_grow) begin
                        n_sum_x = r_sum_x + SUM_BITS'(r_item.x);
                        n_sum_y = r_sum_y + SUM_BITS'(r_item.y);
                        n_count = r_count + 2'd1;
                    end
                    if (n_count >= 2'(STABLE_COUNT) && n_count != 2'd0) begin
                        n_ref_x  = r_rx[COORD_BITS-1:0];
                        n_ref_y  = r_ry[COORD_BITS-1:0];
                        n_acc_dx = '0;
                        n_acc_dy = '0;
                        n_phase  = PH_DRAG;
                    end
                end else begin
                    adx = r_acc_dx + (ACC_BITS'(r_item.x) - ACC_BITS'(r_ref_x));
                    ady = r_acc_dy + (ACC_BITS'(r_item.y) - ACC_BITS'(r_ref_y));
                    n_ref_x = r_item.x;
                    n_ref_y = r_item.y;
                    mx = abs16(adx);
                    my = abs16(ady);
                    if (r_item.mode == MODE_PLAYER) begin
                        if (mx > 17'(th) || my > 17'(th)) n_slid = 1'b1;
                        // right edge strip gives brightness steps
                        if (12'(r_item.x) >= w_right && my > 17'(th)) begin
                            w_code[w_n[0]] = (!ady[15] && ady != '0) ?
                                             EV_BRIGHT_DN : EV_BRIGHT_UP;
                            w_n = w_n + 2'd1;
                            ady = '0;
                        end
                        dt = r_item.now_ms - r_press_ms;
                        if (!n_slid && dt > 32'(i_cfg.long_press) &&
                            12'(r_item.y) < w_upper) begin
                            w_code[w_n[0]] = (12'(r_item.x) < w_half) ?
                                             EV_LONG_LEFT : EV_LONG_RIGHT;
                            w_n = w_n + 2'd1;
                            n_phase = PH_LONG;
                            n_slid  = 1'b1;
                        end else if (mx > 17'(th)) begin
                            if (12'(r_item.y) < w_upper)
                                w_code[w_n[0]] = (!adx[15] && adx != '0) ? EV_PREV : EV_NEXT;
                            else
                                w_code[w_n[0]] = (!adx[15] && adx != '0) ?
                                                 EV_VOL_UP : EV_VOL_DN;
                            w_n = w_n + 2'd1;
                            adx = '0;
                        end
                    end else if (r_item.mode == MODE_LIST) begin
                        if (my > 17'(th)) begin
                            w_code[w_n[0]] = (!ady[15] && ady != '0) ?
                                             EV_LIST_DN : EV_LIST_UP;
                            w_n = w_n + 2'd1;
                            ady = '0;
                            n_slid = 1'b1;
                        end
                    end else begin
                        if (mx > 17'(th)) begin
                            w_code[w_n[0]] = (!adx[15] && adx != '0) ?
                                             EV_VOL_UP : EV_VOL_DN;
                            w_n = w_n + 2'd1;
                            adx = '0;
                            n_slid = 1'b1;
                        end
                    end
                    n_acc_dx = adx;
                    n_acc_dy = ady;
                end
            end
        end
    end

    assign o_wr_n     = w_fire ? w_n : 2'd0;
    assign o_ev0.code = w_code[0];
    assign o_ev0.last = (w_n == 2'd1);
    assign o_ev1.code = w_code[1];
    assign o_ev1.last = 1'b1;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_item <= i_item;
        unique case (r_state)
            S_Q0:    r_ty <= w_quot;
            S_Q1:    r_rx <= w_quot;
            S_Q2:    r_ry <= w_quot;
            default: r_ty <= r_ty;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_IDLE;
            r_press_ms <= '0;
            r_last_ms  <= '0;
            r_ref_x    <= '0;
            r_ref_y    <= '0;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_count    <= '0;
            r_acc_dx   <= '0;
            r_acc_dy   <= '0;
            r_slid     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE:  if (o_pop) r_state <= S_Q0;
                S_Q0:    r_state <= S_Q1;
                S_Q1:    r_state <= S_Q2;
                S_Q2:    r_state <= S_EXEC;
                S_EXEC:  if (w_fire) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (w_fire) begin
                r_phase    <= n_phase;
                r_press_ms <= n_press_ms;
                r_last_ms  <= n_last_ms;
                r_ref_x    <= n_ref_x;
                r_ref_y    <= n_ref_y;
                r_sum_x    <= n_sum_x;
                r_sum_y    <= n_sum_y;
                r_count    <= n_count;
                r_acc_dx   <= n_acc_dx;
                r_acc_dy   <= n_acc_dy;
                r_slid     <= n_slid;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/touch_gesture_recognizer.sv =====
// Touch gesture recognizer. Each touch report pushed in yields zero, one or two
// gesture events, popped from the result queue in order; the last event of a
// report has o_last_event set. The back end works through a report in steps:
// it loads it, makes three passes through the shared small divider (tap
// average and the two reference averages), then decides and writes the events
// once the event queue has room for two; it takes no new report before it is
// done with the last. A two-entry input queue and a four-entry event queue
// decouple the sides. Registers sit on an APB port at byte address 4*index.
// depends on tgr_pkg, tgr_front, tgr_core, tgr_evq
`default_nettype none

module touch_gesture_recognizer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [4:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic                           i_touched,
    input  wire logic [tgr_pkg::COORD_BITS-1:0] i_pos_x,
    input  wire logic [tgr_pkg::COORD_BITS-1:0] i_pos_y,
    input  wire logic [31:0]                    i_now_ms,
    input  wire logic [1:0]                     i_screen_mode,
    output logic                                empty,
    input  wire logic                           pop,
    output logic [3:0]                          o_gesture_event,
    output logic                                o_last_event
);
    import tgr_pkg::*;

    t_cfg        r_cfg;
    logic        w_wr;
    logic [2:0]  w_idx;
    logic        w_fe_valid, w_fe_pop;
    t_item       w_fe_item;
    logic [2:0]  w_q_count;
    logic [1:0]  w_wr_n;
    t_event      w_ev0, w_ev1, w_head;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled    <= 1'b1;
            r_cfg.width      <= 12'd320;
            r_cfg.height     <= 12'd240;
            r_cfg.slide_th   <= 10'd30;
            r_cfg.tap_max    <= 16'd500;
            r_cfg.long_press <= 16'd1500;
            r_cfg.list_tmo   <= 16'd5000;
            r_cfg.vol_tmo    <= 16'd3000;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ENABLE:   r_cfg.enabled    <= pwdata[0];
                REG_WIDTH:    r_cfg.width      <= pwdata[11:0];
                REG_HEIGHT:   r_cfg.height     <= pwdata[11:0];
                REG_SLIDE:    r_cfg.slide_th   <= pwdata[9:0];
                REG_TAP_MAX:  r_cfg.tap_max    <= pwdata[15:0];
                REG_LONG:     r_cfg.long_press <= pwdata[15:0];
                REG_LIST_TMO: r_cfg.list_tmo   <= pwdata[15:0];
                REG_VOL_TMO:  r_cfg.vol_tmo    <= pwdata[15:0];
                default:      r_cfg.enabled    <= r_cfg.enabled;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ENABLE:   prdata = 32'(r_cfg.enabled);
            REG_WIDTH:    prdata = 32'(r_cfg.width);
            REG_HEIGHT:   prdata = 32'(r_cfg.height);
            REG_SLIDE:    prdata = 32'(r_cfg.slide_th);
            REG_TAP_MAX:  prdata = 32'(r_cfg.tap_max);
            REG_LONG:     prdata = 32'(r_cfg.long_press);
            REG_LIST_TMO: prdata = 32'(r_cfg.list_tmo);
            REG_VOL_TMO:  prdata = 32'(r_cfg.vol_tmo);
            default:      prdata = '0;
        endcase
    end

    tgr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_touched     (i_touched),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_now_ms      (i_now_ms),
        .i_screen_mode (i_screen_mode),
        .i_width       (r_cfg.width),
        .i_height      (r_cfg.height),
        .o_valid       (w_fe_valid),
        .o_item        (w_fe_item),
        .i_pop         (w_fe_pop)
    );

    tgr_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (w_fe_valid),
        .i_item    (w_fe_item),
        .o_pop     (w_fe_pop),
        .i_q_count (w_q_count),
        .o_wr_n    (w_wr_n),
        .o_ev0     (w_ev0),
        .o_ev1     (w_ev1)
    );

    tgr_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_n  (w_wr_n),
        .i_ev0   (w_ev0),
        .i_ev1   (w_ev1),
        .o_count (w_q_count),
        .o_empty (empty),
        .o_head  (w_head),
        .i_pop   (pop)
    );

    assign o_gesture_event = w_head.code;
    assign o_last_event    = w_head.last;

endmodule

`default_nettype wire
